// ===== hw/rtl/rate_smoothed_value_predictor_top_defines.svh =====
// Assertion macros shared by the predictor modules.
// They expect clk and arst_n to be visible in the module that uses them.
`ifndef RATE_SMOOTHED_VALUE_PREDICTOR_TOP_DEFINES_SVH
`define RATE_SMOOTHED_VALUE_PREDICTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define RSVP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsvp assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define RSVP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsvp assertion failed");

`endif

// ===== hw/rtl/rsvp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsvp_pkg;

	// Field widths.
	localparam int SAMPLE_W  = 32;
	localparam int STEP_W    = 18;
	localparam int HORIZON_W = 16;
	localparam int GAIN_W    = 17;
	localparam int CFG_IDX_W = 1;
	localparam int TDATA_W   = 56;

	// Fixed-point constants.
	localparam int STEP_FRAC    = 16;
	localparam int HORIZON_FRAC = 12;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

	// Divider: |diff| is 33 bits, scaled by 2^16, giving 49 quotient bits.
	localparam int DIV_STEPS = 49;
	localparam int DIV_CNT_W = 6;

	// Multiplier operand and product widths.
	localparam int MUL_A_W = 18;
	localparam int PROD_W  = MUL_A_W + SAMPLE_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HORIZON = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 1'd1;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_RATE,
		ST_AVG_OLD,
		ST_AVG_NEW,
		ST_AVG,
		ST_BLD_OLD,
		ST_BLD_NEW,
		ST_BLEND,
		ST_HOR,
		ST_PRED
	} ctrl_state_t;

	// Datapath operations.
	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_DIV,
		DP_RATE,
		DP_MUL_AVG_OLD,
		DP_MUL_AVG_NEW,
		DP_AVG,
		DP_MUL_BLD_OLD,
		DP_MUL_BLD_NEW,
		DP_BLEND,
		DP_MUL_HOR,
		DP_PRED
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic item_en;
		logic item_dt_zero;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsvp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "rate_smoothed_value_predictor_top_defines.svh"

module rsvp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_tvalid,
	output logic                    in_tready,
	input  wire rsvp_pkg::dp_status_t status,
	output rsvp_pkg::dp_cmd_t       cmd
);
	import rsvp_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic div_last;

	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// State and divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV && !div_last) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_tvalid && status.item_en && !status.item_dt_zero) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_RATE;
				end
			end
			ST_RATE:    state_d = ST_AVG_OLD;
			ST_AVG_OLD: state_d = ST_AVG_NEW;
			ST_AVG_NEW: state_d = ST_AVG;
			ST_AVG:     state_d = ST_BLD_OLD;
			ST_BLD_OLD: state_d = ST_BLD_NEW;
			ST_BLD_NEW: state_d = ST_BLEND;
			ST_BLEND:   state_d = ST_HOR;
			ST_HOR:     state_d = ST_PRED;
			ST_PRED: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs: one datapath operation per state.
	always_comb begin
		in_tready = 1'b0;
		cmd.op    = DP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					cmd.op = DP_LOAD;
				end
			end
			ST_DIV:     cmd.op = DP_DIV;
			ST_RATE:    cmd.op = DP_RATE;
			ST_AVG_OLD: cmd.op = DP_MUL_AVG_OLD;
			ST_AVG_NEW: cmd.op = DP_MUL_AVG_NEW;
			ST_AVG:     cmd.op = DP_AVG;
			ST_BLD_OLD: cmd.op = DP_MUL_BLD_OLD;
			ST_BLD_NEW: cmd.op = DP_MUL_BLD_NEW;
			ST_BLEND:   cmd.op = DP_BLEND;
			ST_HOR:     cmd.op = DP_MUL_HOR;
			ST_PRED: begin
				if (status.out_free) begin
					cmd.op = DP_PRED;
				end
			end
			default:    cmd.op = DP_NONE;
		endcase
	end

	// An enabled item with a nonzero step starts a fresh division.
	`RSVP_ASSERT_NEXT(a_div_start, state_q == ST_IDLE && in_tvalid && status.item_en && !status.item_dt_zero, state_q == ST_DIV && div_cnt_q == '0)
	// The result register is never overwritten while it still holds an item.
	`RSVP_ASSERT_IMP(a_pred_free, cmd.op == DP_PRED, status.out_free)
	// The step counter only runs during the division.
	`RSVP_ASSERT_IMP(a_cnt_idle, state_q != ST_DIV, div_cnt_q == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/rsvp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "rate_smoothed_value_predictor_top_defines.svh"

module rsvp_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rsvp_pkg::dp_cmd_t                   cmd,
	output rsvp_pkg::dp_status_t                     status,
	input  wire logic [rsvp_pkg::SAMPLE_W-1:0]       sample_value,
	input  wire logic [rsvp_pkg::STEP_W-1:0]         time_step,
	input  wire logic                                enable,
	input  wire logic                                cfg_valid,
	input  wire logic [rsvp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rsvp_pkg::GAIN_W-1:0]         cfg_data,
	output logic [rsvp_pkg::SAMPLE_W-1:0]            predicted_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready
);
	import rsvp_pkg::*;

	localparam int QUO_W = DIV_STEPS;

	// Configuration registers.
	logic [HORIZON_W-1:0] horizon_q;
	logic [GAIN_W-1:0]    gain_q;

	// Persistent state.
	logic [SAMPLE_W-1:0] prev_q;
	logic                have_prev_q;
	logic [SAMPLE_W-1:0] avg_q;

	// Per-item working registers.
	logic [SAMPLE_W-1:0] sample_q;
	logic [STEP_W-1:0]   dt_q;
	logic                neg_q;
	logic [QUO_W-1:0]    dvd_q;
	logic [STEP_W-1:0]   rem_q;
	logic [SAMPLE_W-1:0] rate_q;
	logic [SAMPLE_W-1:0] blend_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PROD_W-1:0]   acc_q;
	logic [SAMPLE_W-1:0] out_q;
	logic                out_valid_q;

	logic [SAMPLE_W-1:0] prev_eff;
	logic [SAMPLE_W:0]   diff;
	logic [SAMPLE_W:0]   mag;
	logic [STEP_W:0]     trial;
	logic [SAMPLE_W-1:0] rate_sat;
	logic [GAIN_W-1:0]   gain_eff;
	logic [MUL_A_W-1:0]  mul_a;
	logic [SAMPLE_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [PROD_W:0]     mac_sum;
	logic [SAMPLE_W+6:0] pred_sum;
	logic [SAMPLE_W-1:0] pred_sat;

	// Status toward the controller.
	assign status.item_en      = enable;
	assign status.item_dt_zero = (time_step == '0);
	assign status.out_free     = !out_valid_q || out_ready;
	assign predicted_value     = out_q;
	assign out_valid           = out_valid_q;

	// Difference to the previous sample; the first sample is its own predecessor.
	assign prev_eff = have_prev_q ? prev_q : sample_value;
	assign diff = {sample_value[SAMPLE_W-1], sample_value} - {prev_eff[SAMPLE_W-1], prev_eff};
	assign mag  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

	// One restoring division step.
	assign trial = {rem_q, dvd_q[QUO_W-1]} - {1'b0, dt_q};

	// Saturate the signed quotient to 32 bits.
	always_comb begin
		if (!neg_q) begin
			rate_sat = (|dvd_q[QUO_W-1:SAMPLE_W-1]) ? 32'h7FFF_FFFF : dvd_q[SAMPLE_W-1:0];
		end else if ((|dvd_q[QUO_W-1:SAMPLE_W]) ||
				(dvd_q[SAMPLE_W-1] && (|dvd_q[SAMPLE_W-2:0]))) begin
			rate_sat = 32'h8000_0000;
		end else begin
			rate_sat = ~dvd_q[SAMPLE_W-1:0] + 1'b1;
		end
	end

	// Gain above one counts as one.
	assign gain_eff = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			DP_MUL_AVG_OLD: begin
				mul_a = MUL_A_W'({1'b0, GAIN_ONE} - {1'b0, dt_q[GAIN_W-1:0]});
				mul_b = avg_q;
			end
			DP_MUL_AVG_NEW: begin
				mul_a = dt_q;
				mul_b = rate_q;
			end
			DP_MUL_BLD_OLD: begin
				mul_a = MUL_A_W'({1'b0, GAIN_ONE} - {1'b0, gain_eff});
				mul_b = avg_q;
			end
			DP_MUL_BLD_NEW: begin
				mul_a = {1'b0, gain_eff};
				mul_b = rate_q;
			end
			DP_MUL_HOR: begin
				mul_a = {2'b00, horizon_q};
				mul_b = blend_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Signed 18x32 product at full width.
	assign mul_p = $signed(mul_a) * $signed(mul_b);

	// Weighted sum of the two registered products.
	assign mac_sum = {acc_q[PROD_W-1], acc_q} + {prod_q[PROD_W-1], prod_q};

	// Sample plus scaled extrapolation, saturated.
	assign pred_sum = {{7{sample_q[SAMPLE_W-1]}}, sample_q} +
			{prod_q[PROD_W-1], prod_q[PROD_W-1:HORIZON_FRAC]};
	always_comb begin
		if (!pred_sum[SAMPLE_W+6] && (|pred_sum[SAMPLE_W+5:SAMPLE_W-1])) begin
			pred_sat = 32'h7FFF_FFFF;
		end else if (pred_sum[SAMPLE_W+6] && !(&pred_sum[SAMPLE_W+5:SAMPLE_W-1])) begin
			pred_sat = 32'h8000_0000;
		end else begin
			pred_sat = pred_sum[SAMPLE_W-1:0];
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q <= '0;
			gain_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HORIZON: horizon_q <= cfg_data[HORIZON_W-1:0];
				CFG_GAIN:    gain_q    <= cfg_data;
				default:     gain_q    <= gain_q;
			endcase
		end
	end

	// State and divider registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			avg_q       <= '0;
			dt_q        <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result fills the output register; a taken result empties it.
			if (cmd.op == DP_PRED) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				DP_LOAD: begin
					if (enable) begin
						prev_q      <= sample_value;
						have_prev_q <= 1'b1;
						dt_q        <= time_step;
						rem_q       <= '0;
					end
				end
				DP_DIV: begin
					if (!trial[STEP_W]) begin
						rem_q <= trial[STEP_W-1:0];
					end else begin
						rem_q <= {rem_q[STEP_W-2:0], dvd_q[QUO_W-1]};
					end
				end
				DP_AVG: begin
					if (dt_q < {1'b0, GAIN_ONE}) begin
						avg_q <= mac_sum[STEP_FRAC+SAMPLE_W-1:STEP_FRAC];
					end else begin
						avg_q <= rate_q;
					end
				end
				default: begin
					avg_q <= avg_q;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				sample_q <= sample_value;
				neg_q    <= diff[SAMPLE_W];
				dvd_q    <= {mag, {STEP_FRAC{1'b0}}};
			end
			DP_DIV: begin
				dvd_q <= {dvd_q[QUO_W-2:0], !trial[STEP_W]};
			end
			DP_RATE: begin
				rate_q <= rate_sat;
			end
			DP_MUL_AVG_OLD, DP_MUL_AVG_NEW, DP_MUL_BLD_OLD, DP_MUL_BLD_NEW,
			DP_MUL_HOR: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			DP_BLEND: begin
				blend_q <= mac_sum[STEP_FRAC+SAMPLE_W-1:STEP_FRAC];
			end
			DP_PRED: begin
				out_q <= pred_sat;
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

	// The partial remainder always stays below the divisor.
	`RSVP_ASSERT_IMP(a_rem_bound, dt_q != '0, rem_q < dt_q)
	// Once a sample is seen, the block never forgets it.
	`RSVP_ASSERT_NEXT(a_prev_kept, have_prev_q, have_prev_q)

endmodule

`default_nettype wire

// ===== hw/rtl/rate_smoothed_value_predictor_top.sv =====
// Rate-smoothed value predictor. Each input item carries a signed Q16.16 sample,
// a Q2.16 time step and an enable flag. An enabled item with a nonzero step yields
// one predicted value: the sample extrapolated over the horizon register using a
// gain-weighted mix of the instantaneous and averaged rates, saturated to 32 bits.
// Disabled items and zero-step items produce nothing. An item that produces a
// result occupies the block while it is loaded, runs through the bit-serial rate
// divider (one quotient bit per cycle), has its rate saturated, runs the shared
// 18x32 multiplier sequence and fills the output register.
// The finished item sits in that output register, so the next item is accepted
// while it waits; a result still waiting when the next one is done stalls the
// block. Configuration writes are taken at any time but should only be issued
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module rate_smoothed_value_predictor_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input items.
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [31:0] sample_value, [49:32] time_step, [55:50] zero
	input  wire logic [rsvp_pkg::TDATA_W-1:0]      s_axis_tdata,
	// [0] enable
	input  wire logic                              s_axis_tuser,
	// Result items.
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [31:0] predicted_value
	output logic [rsvp_pkg::SAMPLE_W-1:0]          m_axis_tdata,
	// Configuration writes.
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rsvp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rsvp_pkg::GAIN_W-1:0]       cfg_data
);
	import rsvp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Registers accept writes in any cycle.
	assign cfg_ready = 1'b1;

	// Sequencer.
	rsvp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// Divider, multiplier and state registers.
	rsvp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.sample_value    (s_axis_tdata[SAMPLE_W-1:0]),
		.time_step       (s_axis_tdata[SAMPLE_W+STEP_W-1:SAMPLE_W]),
		.enable          (s_axis_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.predicted_value (m_axis_tdata),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready)
	);

endmodule

`default_nettype wire

// ===== test/rate_smoothed_value_predictor_top_tb.sv =====
`timescale 1ns / 1ps

module rate_smoothed_value_predictor_top_tb;
	import rsvp_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS   = 222;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [STEP_W-1:0]          step;
		logic                       en;
	} sensor_item_t;

	// Clock, reset and block ports.
	logic clk = 1'b1;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;

	// Items waiting to be driven and predictions waiting to come out.
	sensor_item_t sample_q[$];
	logic [SAMPLE_W-1:0] predicted_q[$];

	// Predictor state and register copies.
	longint last_sample;
	bit have_last;
	longint avg_rate;
	logic [HORIZON_W-1:0] horizon_reg;
	logic [GAIN_W-1:0] gain_reg;

	// Stimulus knobs and bookkeeping.
	int send_idle_pct = 13;
	int recv_idle_pct = 57;
	bit item_taken;
	logic signed [SAMPLE_W-1:0] walk_value;
	int cycle_count = 0;
	int errors = 0;
	int items_accepted = 0;
	int items_disabled = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int settings_used = 0;

	rate_smoothed_value_predictor_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Free-running clock, 20 ns period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d predictions outstanding.",
				cycle_count, predicted_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH (cycle %0d): %s", cycle_count, msg);
		errors++;
	endtask

	function automatic longint clip32(input longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// Extrapolate one item; returns 1 when the item yields a prediction.
	function automatic bit extrapolate(input sensor_item_t it, output logic [SAMPLE_W-1:0] value);
		longint diff, mag, quot, rate, weight, gain_eff, blend, ext;
		value = '0;
		if (!it.en)
			return 1'b0;
		if (!have_last) begin
			last_sample = longint'(it.sample);
			have_last = 1'b1;
		end
		if (it.step == '0) begin
			last_sample = longint'(it.sample);
			return 1'b0;
		end
		// Instantaneous rate, truncated toward zero and saturated.
		diff = longint'(it.sample) - last_sample;
		mag = (diff < 0 ? -diff : diff) <<< STEP_FRAC;
		weight = longint'(it.step);
		quot = mag / weight;
		rate = clip32(diff < 0 ? -quot : quot);
		// Time-weighted average, replaced outright for steps of a second or more.
		if (weight < 65536)
			avg_rate = ((65536 - weight) * avg_rate + weight * rate) >>> STEP_FRAC;
		else
			avg_rate = rate;
		// Gain-weighted blend, with the gain clamped to one.
		gain_eff = (gain_reg > GAIN_ONE) ? 64'sd65536 : longint'(gain_reg);
		blend = ((65536 - gain_eff) * avg_rate + gain_eff * rate) >>> 16;
		ext = (longint'(horizon_reg) * blend) >>> HORIZON_FRAC;
		value = SAMPLE_W'(clip32(longint'(it.sample) + ext));
		last_sample = longint'(it.sample);
		return 1'b1;
	endfunction

	// Input item driver: presents the next queued item at the falling edge.
	always @(negedge clk) begin
		sensor_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || item_taken) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {{(TDATA_W - SAMPLE_W - STEP_W){1'b0}}, it.step, it.sample};
				s_axis_tuser <= it.en;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Accepted input items feed the predictor.
	always @(posedge clk) begin
		sensor_item_t it;
		logic [SAMPLE_W-1:0] value;
		item_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (item_taken) begin
			it.sample = s_axis_tdata[SAMPLE_W-1:0];
			it.step = s_axis_tdata[SAMPLE_W +: STEP_W];
			it.en = s_axis_tuser;
			items_accepted++;
			if (!it.en)
				items_disabled++;
			if (extrapolate(it, value))
				predicted_q.insert(predicted_q.size(), value);
		end
	end

	// Result receiver: random backpressure at the falling edge.
	always @(negedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Result monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		logic [SAMPLE_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (predicted_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
			end else begin
				want = predicted_q.pop_front();
				results_checked++;
				if (m_axis_tdata !== want)
					report_mismatch($sformatf("predicted_value %h, expected %h",
						m_axis_tdata, want));
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_HORIZON)
			horizon_reg = val[HORIZON_W-1:0];
		else
			gain_reg = val;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [GAIN_W-1:0] horizon, input logic [GAIN_W-1:0] gain);
		write_reg(CFG_HORIZON, horizon);
		write_reg(CFG_GAIN, gain);
		settings_used++;
	endtask

	task automatic add_item(input logic [SAMPLE_W-1:0] sample, input logic [STEP_W-1:0] step,
			input logic en);
		sensor_item_t it;
		it.sample = sample;
		it.step = step;
		it.en = en;
		sample_q.insert(sample_q.size(), it);
	endtask

	// Wait until every item is in and every prediction is out, then let the block settle.
	task automatic drain();
		while (sample_q.size() != 0 || s_axis_tvalid || predicted_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly enabled items with a random walk of samples, plus noise and odd cases.
	task automatic add_random_items(input int count);
		sensor_item_t it;
		int unsigned pick;
		int unsigned shape;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			shape = $urandom_range(99);
			it.en = (pick >= 8);
			if (pick < 8)
				it.step = STEP_W'($urandom_range(262143));
			else if (pick < 13)
				it.step = '0;
			else if (shape < 50)
				it.step = STEP_W'($urandom_range(4095, 1));
			else if (shape < 80)
				it.step = STEP_W'($urandom_range(65535, 1));
			else
				it.step = STEP_W'($urandom_range(262143, 1));
			shape = $urandom_range(99);
			if (shape < 60)
				it.sample = walk_value + ($signed($urandom_range(2097151)) - 1048576);
			else if (shape < 85)
				it.sample = $urandom;
			else
				it.sample = $signed($urandom_range(1048575)) - 524288;
			walk_value = it.sample;
			sample_q.insert(sample_q.size(), it);
		end
	endtask

	task automatic run_phase(input logic [GAIN_W-1:0] horizon, input logic [GAIN_W-1:0] gain,
			input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		set_config(horizon, gain);
		add_random_items(PHASE_ITEMS);
		drain();
	endtask

	initial begin
		have_last = 1'b0;
		last_sample = 0;
		avg_rate = 0;
		horizon_reg = '0;
		gain_reg = '0;
		walk_value = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset registers: disabled item first, then the seeding item and a zero step.
		add_item(32'h7fffffff, 18'd262143, 1'b0);
		add_item(32'h0064_0000, 18'h04000, 1'b1);
		add_item(32'h00c8_0000, 18'd0, 1'b1);
		add_item(32'h012c_0000, 18'd1, 1'b1);
		add_item(32'h80000000, 18'd65535, 1'b1);
		add_item(32'h7fffffff, 18'd65536, 1'b1);
		add_item(32'h00000000, 18'd262143, 1'b1);
		add_item(32'h00000005, 18'd0, 1'b0);
		drain();

		// Longest horizon and a gain above one: rate and prediction saturate both ways.
		set_config(17'h0ffff, 17'h1ffff);
		add_item(32'h80000000, 18'd1000, 1'b1);
		add_item(32'h7fffffff, 18'd1, 1'b1);
		add_item(32'h80000000, 18'd1, 1'b1);
		add_item(32'hffffffff, 18'd3, 1'b1);
		add_item(32'h00000000, 18'd65536, 1'b1);
		drain();

		// Gain of exactly one.
		set_config(17'h08000, 17'h10000);
		add_item(32'h0001_0000, 18'd32768, 1'b1);
		add_item(32'h0002_0000, 18'd16384, 1'b1);
		add_item(32'hfffb_0000, 18'd65535, 1'b1);
		add_item(32'h00000000, 18'd2, 1'b0);
		add_item(32'h00000007, 18'h3ffff, 1'b1);
		drain();

		// Random phases under several register settings and backpressure patterns.
		run_phase(17'h01000, 17'h00000, 13, 57);
		run_phase(17'h0ffff, 17'h10000, 13, 57);
		run_phase(17'h10000 | 17'($urandom_range(65535)), 17'($urandom_range(65535)), 57, 13);
		run_phase(17'h00000, 17'h1ffff, 57, 13);
		run_phase(17'($urandom_range(131071)), 17'($urandom_range(131071)), 0, 0);
		run_phase(17'h03000, 17'h04000, 0, 0);

		if (predicted_q.size() != 0)
			report_mismatch($sformatf("%0d predictions never arrived", predicted_q.size()));
		$display("Run covered %0d input items (%0d disabled) and checked %0d predictions,",
			items_accepted, items_disabled, results_checked);
		$display("with %0d register writes over %0d settings and %0d mismatches.",
			reg_writes, settings_used, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
